/* rtl/ggpd_pkg.sv */
`timescale 1ns / 1ps
package ggpd_pkg;

  localparam int NUM_REGS     = 7;
  localparam int CORDIC_STEPS = 31;
  localparam int RED_STEPS    = 13;
  localparam int QUEUE_DEPTH_DEF = 4;

  // register indexes
  localparam logic [2:0] REG_GAIN_P_X       = 3'd0;
  localparam logic [2:0] REG_GAIN_P_Y       = 3'd1;
  localparam logic [2:0] REG_GAIN_P_HEADING = 3'd2;
  localparam logic [2:0] REG_GAIN_D_SPEED   = 3'd3;
  localparam logic [2:0] REG_GAIN_D_RATE    = 3'd4;
  localparam logic [2:0] REG_GOAL_X         = 3'd5;
  localparam logic [2:0] REG_GOAL_Y         = 3'd6;

  // angle constants, Q2.30 unless noted
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [34:0] HALF_PI_Q16 = 35'sd102944;
  localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] fwd_speed;
    logic signed [31:0] yaw_rate;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] cmd_linear;
    logic signed [31:0] cmd_angular;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] gain_p_x;
    logic signed [31:0] gain_p_y;
    logic signed [31:0] gain_p_heading;
    logic signed [31:0] gain_d_speed;
    logic signed [31:0] gain_d_rate;
  } gain_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] heading;
    logic        [31:0] habs;
    logic               hneg;
    logic        [31:0] spd;
    logic signed [31:0] rate;
  } entry_t;

  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] v;
    case (i)
      5'd0:  v = 35'sd843314857;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043837;
      5'd3:  v = 35'sd133525159;
      5'd4:  v = 35'sd67021687;
      5'd5:  v = 35'sd33543516;
      5'd6:  v = 35'sd16775851;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194283;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048576;
      5'd11: v = 35'sd524288;
      5'd12: v = 35'sd262144;
      5'd13: v = 35'sd131072;
      5'd14: v = 35'sd65536;
      5'd15: v = 35'sd32768;
      5'd16: v = 35'sd16384;
      5'd17: v = 35'sd8192;
      5'd18: v = 35'sd4096;
      5'd19: v = 35'sd2048;
      5'd20: v = 35'sd1024;
      5'd21: v = 35'sd512;
      5'd22: v = 35'sd256;
      5'd23: v = 35'sd128;
      5'd24: v = 35'sd64;
      5'd25: v = 35'sd32;
      5'd26: v = 35'sd16;
      5'd27: v = 35'sd8;
      5'd28: v = 35'sd4;
      5'd29: v = 35'sd2;
      5'd30: v = 35'sd1;
      default: v = 35'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/go_to_goal_pd_controller_unit.sv */
`timescale 1ns / 1ps
// Go-to-goal PD drive controller.
// Pose channel: pose_valid / pose_stall / pose (x, y, heading, speed, yaw rate,
// all signed Q16.16). A transfer happens on a clock edge with pose_valid high
// and pose_stall low. Command channel: cmd_valid / cmd_stall / cmd (linear and
// angular command, Q16.16, saturated to 32 bits), same rule.
// Gains and goal sit in seven registers written through wr_en / wr_index /
// wr_data; index 7 is ignored. Write them only while the block is idle.
// Throughput: one pose per cycle unless cmd_stall holds the back pipeline. The
// path is the front register (loaded at the transfer edge), a queue slot, the
// load stage, the 13-stage modulo-2*pi reduction, the fold stage, the 31-stage
// CORDIC pipeline (cos/sin and atan side by side), the post stage, three
// multiply/round stages and the output register.
// A front register classifies each pose and pushes it into a 4-entry queue;
// the back pipeline pulls from it. When cmd_stall is high while cmd_valid is
// set, the whole back pipeline freezes, the queue fills, then pose_stall rises.
// Reset (rst, synchronous) clears the gain and goal registers to zero, empties
// the queue and drops every valid bit; data pipeline registers are not reset.
module go_to_goal_pd_controller_unit
  import ggpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pose_valid,
  output logic        pose_stall,
  input  pose_t       pose,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output cmd_t        cmd,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  gain_t              gain;
  logic signed [31:0] goal_x, goal_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= '0;
      goal_x <= '0;
      goal_y <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_P_X:       gain.gain_p_x       <= wr_data;
        REG_GAIN_P_Y:       gain.gain_p_y       <= wr_data;
        REG_GAIN_P_HEADING: gain.gain_p_heading <= wr_data;
        REG_GAIN_D_SPEED:   gain.gain_d_speed   <= wr_data;
        REG_GAIN_D_RATE:    gain.gain_d_rate    <= wr_data;
        REG_GOAL_X:         goal_x              <= wr_data;
        REG_GOAL_Y:         goal_y              <= wr_data;
        default: ;
      endcase
    end
  end

  logic   push, full, pop, empty;
  entry_t wdata, rdata;

  // front: position error, heading and speed magnitudes
  ggpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pose_valid (pose_valid),
    .pose       (pose),
    .pose_stall (pose_stall),
    .goal_x     (goal_x),
    .goal_y     (goal_y),
    .full       (full),
    .push       (push),
    .entry      (wdata)
  );

  // decoupling queue between front and back
  ggpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  // back: CORDIC and PD arithmetic, output register
  ggpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain),
    .empty     (empty),
    .rdata     (rdata),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

endmodule

/* rtl/ggpd_front.sv */
`timescale 1ns / 1ps
module ggpd_front
  import ggpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pose_valid,
  input  pose_t              pose,
  output logic               pose_stall,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic               full,
  output logic               push,
  output entry_t             entry
);

  logic   held;
  logic   load;
  entry_t ent_next;

  assign push       = held && !full;
  assign pose_stall = held && full;
  assign load       = pose_valid && (!held || !full);

  always_comb begin
    ent_next.dx      = 33'(goal_x) - 33'(pose.pos_x);
    ent_next.dy      = 33'(goal_y) - 33'(pose.pos_y);
    ent_next.heading = pose.heading;
    ent_next.hneg    = pose.heading[31];
    ent_next.habs    = pose.heading[31] ? (~pose.heading + 32'd1) : pose.heading;
    ent_next.spd     = pose.fwd_speed[31] ? (~pose.fwd_speed + 32'd1) : pose.fwd_speed;
    ent_next.rate    = pose.yaw_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!held || !full) begin
      held <= pose_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= ent_next;
    end
  end

endmodule

/* rtl/ggpd_queue.sv */
`timescale 1ns / 1ps
module ggpd_queue
  import ggpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");
`endif

endmodule

/* rtl/ggpd_back.sv */
`timescale 1ns / 1ps
module ggpd_back
  import ggpd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  gain_t  gain,
  input  logic   empty,
  input  entry_t rdata,
  output logic   pop,
  output logic   cmd_valid,
  input  logic   cmd_stall,
  output cmd_t   cmd
);

  localparam int FOLD_IDX = RED_STEPS + 1;
  localparam int LAST_IDX = FOLD_IDX + CORDIC_STEPS;
  localparam int NVLD     = LAST_IDX + 5;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] heading;
    logic        [31:0] spd;
    logic signed [31:0] rate;
    logic        [45:0] acc;
    logic               hneg;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [34:0] rz;
    logic               flip;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [34:0] vz;
  } pl_t;

  logic            en;
  logic [NVLD-1:0] vld;
  pl_t             stg [LAST_IDX+1];

  assign en  = !cmd_valid || !cmd_stall;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      cmd_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NVLD-2:0], pop};
      cmd_valid <= vld[NVLD-1];
    end
  end

  // load from queue
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].dx      <= rdata.dx;
      stg[0].dy      <= rdata.dy;
      stg[0].heading <= rdata.heading;
      stg[0].spd     <= rdata.spd;
      stg[0].rate    <= rdata.rate;
      stg[0].acc     <= {rdata.habs, 14'd0};
      stg[0].hneg    <= rdata.hneg;
      stg[0].rx      <= '0;
      stg[0].ry      <= '0;
      stg[0].rz      <= '0;
      stg[0].flip    <= 1'b0;
      stg[0].vx      <= '0;
      stg[0].vy      <= '0;
      stg[0].vz      <= '0;
    end
  end

  // modulo 2*pi by restoring subtraction, one multiple per stage
  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam logic [46:0] K = 47'(TWO_PI_Q30) << (RED_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        stg[j+1] <= stg[j];
        if ({1'b0, stg[j].acc} >= K) begin
          stg[j+1].acc <= 46'({1'b0, stg[j].acc} - K);
        end
      end
    end
  end

  // fold into [-pi/2, pi/2], seed both CORDICs
  logic signed [35:0] r0, r1, r2;
  logic               fl;
  logic        [32:0] dxa;
  logic signed [33:0] dyv;

  always_comb begin
    r0 = stg[RED_STEPS].hneg ? -36'(stg[RED_STEPS].acc) : 36'(stg[RED_STEPS].acc);
    if (r0 > PI_Q30) begin
      r1 = r0 - TWO_PI_Q30;
    end else if (r0 < -PI_Q30) begin
      r1 = r0 + TWO_PI_Q30;
    end else begin
      r1 = r0;
    end
    fl = 1'b0;
    r2 = r1;
    if (r1 > HALF_PI_Q30) begin
      r2 = r1 - PI_Q30;
      fl = 1'b1;
    end else if (r1 < -HALF_PI_Q30) begin
      r2 = r1 + PI_Q30;
      fl = 1'b1;
    end
    dxa = stg[RED_STEPS].dx[32] ? 33'(-stg[RED_STEPS].dx) : 33'(stg[RED_STEPS].dx);
    dyv = stg[RED_STEPS].dx[32] ? -34'(stg[RED_STEPS].dy) : 34'(stg[RED_STEPS].dy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[FOLD_IDX]      <= stg[RED_STEPS];
      stg[FOLD_IDX].rx   <= INV_GAIN;
      stg[FOLD_IDX].ry   <= '0;
      stg[FOLD_IDX].rz   <= 35'(r2);
      stg[FOLD_IDX].flip <= fl;
      stg[FOLD_IDX].vx   <= $signed({31'd0, dxa}) <<< 28;
      stg[FOLD_IDX].vy   <= 64'(dyv) <<< 28;
      stg[FOLD_IDX].vz   <= '0;
    end
  end

  // rotation (cos/sin) and vectoring (atan) CORDIC, one iteration per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int S = FOLD_IDX + i;
    always_ff @(posedge clk) begin
      if (en) begin
        stg[S+1] <= stg[S];
        if (stg[S].rz >= 0) begin
          stg[S+1].rx <= stg[S].rx - (stg[S].ry >>> i);
          stg[S+1].ry <= stg[S].ry + (stg[S].rx >>> i);
          stg[S+1].rz <= stg[S].rz - atan_q30(5'(i));
        end else begin
          stg[S+1].rx <= stg[S].rx + (stg[S].ry >>> i);
          stg[S+1].ry <= stg[S].ry - (stg[S].rx >>> i);
          stg[S+1].rz <= stg[S].rz + atan_q30(5'(i));
        end
        if (stg[S].vy >= 0) begin
          stg[S+1].vx <= stg[S].vx + (stg[S].vy >>> i);
          stg[S+1].vy <= stg[S].vy - (stg[S].vx >>> i);
          stg[S+1].vz <= stg[S].vz + atan_q30(5'(i));
        end else begin
          stg[S+1].vx <= stg[S].vx - (stg[S].vy >>> i);
          stg[S+1].vy <= stg[S].vy + (stg[S].vx >>> i);
          stg[S+1].vz <= stg[S].vz - atan_q30(5'(i));
        end
      end
    end
  end

  // post: clamp, flip, target angle, heading error
  pl_t                l;
  logic signed [33:0] cc, ss;
  logic signed [34:0] tgt;

  assign l = stg[LAST_IDX];

  always_comb begin
    cc = (l.rx > ONE_Q30) ? ONE_Q30 : ((l.rx < -ONE_Q30) ? -ONE_Q30 : l.rx);
    ss = (l.ry > ONE_Q30) ? ONE_Q30 : ((l.ry < -ONE_Q30) ? -ONE_Q30 : l.ry);
    if (l.dx == '0) begin
      if (l.dy == '0) begin
        tgt = '0;
      end else if (l.dy[32]) begin
        tgt = -HALF_PI_Q16;
      end else begin
        tgt = HALF_PI_Q16;
      end
    end else begin
      tgt = (l.vz + 35'sd8192) >>> 14;
    end
  end

  logic signed [31:0] p_c, p_s, p_rate;
  logic signed [32:0] p_dx, p_dy;
  logic        [31:0] p_spd;
  logic signed [34:0] p_herr;

  always_ff @(posedge clk) begin
    if (en) begin
      p_c    <= 32'(l.flip ? -cc : cc);
      p_s    <= 32'(l.flip ? -ss : ss);
      p_dx   <= l.dx;
      p_dy   <= l.dy;
      p_spd  <= l.spd;
      p_rate <= l.rate;
      p_herr <= tgt - 35'(l.heading);
    end
  end

  // first products
  logic signed [64:0] a_cdx, a_sdy, a_spd;
  logic signed [66:0] a_hd;
  logic signed [63:0] a_rt;

  always_ff @(posedge clk) begin
    if (en) begin
      a_cdx <= 65'(p_c) * 65'(p_dx);
      a_sdy <= 65'(p_s) * 65'(p_dy);
      a_spd <= 65'(gain.gain_d_speed) * $signed({33'd0, p_spd});
      a_hd  <= 67'(gain.gain_p_heading) * 67'(p_herr);
      a_rt  <= 64'(gain.gain_d_rate) * 64'(p_rate);
    end
  end

  // rounding of first products
  logic signed [35:0] b_p1, b_p2;
  logic signed [48:0] b_t3;
  logic signed [51:0] b_mom;

  always_ff @(posedge clk) begin
    if (en) begin
      b_p1  <= 36'((a_cdx + 65'sd536870912) >>> 30);
      b_p2  <= 36'((a_sdy + 65'sd536870912) >>> 30);
      b_t3  <= 49'((a_spd + 65'sd32768) >>> 16);
      b_mom <= 52'((a_hd + 67'sd32768) >>> 16) - 52'((a_rt + 64'sd32768) >>> 16);
    end
  end

  // gain products
  logic signed [67:0] c_q1, c_q2;
  logic signed [48:0] c_t3;
  logic signed [51:0] c_mom;

  always_ff @(posedge clk) begin
    if (en) begin
      c_q1  <= 68'(gain.gain_p_x) * 68'(b_p1);
      c_q2  <= 68'(gain.gain_p_y) * 68'(b_p2);
      c_t3  <= b_t3;
      c_mom <= b_mom;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -56'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  logic signed [55:0] force_sum;

  assign force_sum = 56'((c_q1 + 68'sd32768) >>> 16) + 56'((c_q2 + 68'sd32768) >>> 16)
                   - 56'(c_t3);

  always_ff @(posedge clk) begin
    if (en) begin
      cmd.cmd_linear  <= sat32(force_sum);
      cmd.cmd_angular <= sat32(56'(c_mom));
    end
  end

endmodule
